// ===== hdl/line_follow_pid_steering_top_macros.svh =====
// Assertion macros for the line follower PID steering block.
`ifndef LINE_FOLLOW_PID_STEERING_TOP_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition in the same cycle as its trigger.
`define LFPS_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("lfps assertion failed");
// Check a condition in the cycle after its trigger.
`define LFPS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("lfps assertion failed");
`else
`define LFPS_ASSERT_NOW(lbl, clk, rst_n, trig, cond)
`define LFPS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)
`endif
`endif

// ===== hdl/lfps_pkg.sv =====
// Types and constants shared by the line follower PID steering block.
`timescale 1ns / 1ps
package lfps_pkg;

    localparam int SAMPLE_W = 12;
    localparam int BASE_W   = 11;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 8;
    localparam int DIFF_W   = 9;
    localparam int INTEG_W  = 24;
    localparam int SPEED_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PROP_PROD_W  = ERR_W + GAIN_W;
    localparam int DIFF_PROD_W  = DIFF_W + GAIN_W;
    localparam int INTEG_PROD_W = INTEG_W + GAIN_W;
    localparam int SUM_W        = INTEG_PROD_W + 1;
    localparam int FRAC_W       = 8;
    localparam int CORR_W       = SUM_W - FRAC_W;
    localparam int WIDE_W       = CORR_W + 1;

    // error levels of the position table
    localparam logic signed [ERR_W-1:0] TAPE_ONE_OFF_LEVEL   = 8'sd1;
    localparam logic signed [ERR_W-1:0] TAPE_TWO_OFF_LEVEL   = 8'sd3;
    localparam logic signed [ERR_W-1:0] TAPE_THREE_OFF_LEVEL = 8'sd5;
    localparam logic signed [ERR_W-1:0] IR_ONE_OFF_LEVEL     = 8'sd1;
    localparam logic signed [ERR_W-1:0] ALL_HIGH_CODE        = 8'sd127;

    typedef enum logic {
        MODE_TAPE = 1'b0,
        MODE_IR   = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE            = 3'd0,
        CFG_BASE_SPEED      = 3'd1,
        CFG_GAIN_P          = 3'd2,
        CFG_GAIN_I          = 3'd3,
        CFG_GAIN_D          = 3'd4,
        CFG_WHITE_THRESHOLD = 3'd5,
        CFG_IR_THRESHOLD    = 3'd6
    } cfg_index_t;

    // per-step result fields that ride down the pipeline unchanged
    typedef struct packed {
        logic signed [ERR_W-1:0] error_value;
        logic                    speeds_valid;
        logic                    all_white;
        logic                    all_black;
        logic                    centre_white;
    } step_info_t;

endpackage

// ===== hdl/line_follow_pid_steering_top.sv =====
// Line follower PID steering: sensor thresholding, position error and PID speed pipeline.
//
// Usage: write the seven configuration registers through the cfg channel
// (cfg_index selects the register, cfg_data carries the value) while the
// block is idle; cfg_ready is always high. Each transfer on the s_ channel
// is one step: kind 0 carries three sensor samples, kind 1 clears the last
// error. Every step gives exactly one result transfer on the m_ channel.
// Each step passes through the input register, the error and state stage,
// the gain products, the correction sum and the output register.
// Throughput: one step per cycle while the receiver does not stall; the error
// and integral state is updated in the single error stage, so a step sees
// the state left by the step just before it with no bubble.
// Reset (aresetn low at a clock edge) clears all pipeline valids, the
// configuration registers, the last error and the integral.
// A stalled receiver (m_ready low) holds the output register; the stages
// behind it keep filling, and s_ready falls only once all five are full.
`timescale 1ns / 1ps
`include "line_follow_pid_steering_top_macros.svh"
module line_follow_pid_steering_top (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration writes
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]           cfg_data,
    // step input
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_kind,
    input  logic [lfps_pkg::SAMPLE_W-1:0]             s_left_sample,
    input  logic [lfps_pkg::SAMPLE_W-1:0]             s_centre_sample,
    input  logic [lfps_pkg::SAMPLE_W-1:0]             s_right_sample,
    // step result
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [lfps_pkg::ERR_W-1:0]         m_error_value,
    output logic signed [lfps_pkg::SPEED_W-1:0]       m_left_speed,
    output logic signed [lfps_pkg::SPEED_W-1:0]       m_right_speed,
    output logic                                      m_speeds_valid,
    output logic                                      m_all_white,
    output logic                                      m_all_black,
    output logic                                      m_centre_white
);
    import lfps_pkg::*;

    localparam logic signed [INTEG_W:0] INTEG_MAX = (INTEG_W+1)'(2**(INTEG_W-1) - 1);
    localparam logic signed [INTEG_W:0] INTEG_MIN = -(INTEG_W+1)'(2**(INTEG_W-1));
    localparam logic signed [WIDE_W-1:0] SPEED_MAX = WIDE_W'(2**(SPEED_W-1) - 1);
    localparam logic signed [WIDE_W-1:0] SPEED_MIN = -WIDE_W'(2**(SPEED_W-1));

    // configuration registers
    mode_t                          mode_reg;
    logic signed [BASE_W-1:0]       base_speed_reg;
    logic signed [GAIN_W-1:0]       gain_p_reg;
    logic signed [GAIN_W-1:0]       gain_i_reg;
    logic signed [GAIN_W-1:0]       gain_d_reg;
    logic [SAMPLE_W-1:0]            white_thr_reg;
    logic [SAMPLE_W-1:0]            ir_thr_reg;

    // controller state
    logic signed [ERR_W-1:0]        prev_err_reg;
    logic signed [ERR_W-1:0]        prev_err_next;
    logic signed [INTEG_W-1:0]      integ_reg;
    logic signed [INTEG_W-1:0]      integ_next;

    // input register
    logic                           i_valid_reg;
    kind_t                          i_kind_reg;
    logic [SAMPLE_W-1:0]            i_left_reg;
    logic [SAMPLE_W-1:0]            i_centre_reg;
    logic [SAMPLE_W-1:0]            i_right_reg;

    // error stage
    logic                           a_valid_reg;
    step_info_t                     a_info_reg;
    step_info_t                     a_info_next;
    logic signed [ERR_W-1:0]        a_err_reg;
    logic signed [ERR_W-1:0]        a_err_next;
    logic signed [DIFF_W-1:0]       a_diff_reg;
    logic signed [DIFF_W-1:0]       a_diff_next;
    logic signed [INTEG_W-1:0]      a_integ_reg;

    // product stage
    logic                           b_valid_reg;
    step_info_t                     b_info_reg;
    logic signed [PROP_PROD_W-1:0]  b_prop_reg;
    logic signed [INTEG_PROD_W-1:0] b_integ_reg;
    logic signed [DIFF_PROD_W-1:0]  b_diff_reg;

    // correction stage
    logic                           c_valid_reg;
    step_info_t                     c_info_reg;
    logic signed [CORR_W-1:0]       c_corr_reg;
    logic signed [SUM_W-1:0]        c_sum;
    logic signed [CORR_W-1:0]       c_corr_next;

    // output register
    logic                           m_valid_reg;
    step_info_t                     m_info_reg;
    logic signed [SPEED_W-1:0]      m_left_reg;
    logic signed [SPEED_W-1:0]      m_right_reg;
    logic signed [SPEED_W-1:0]      m_left_next;
    logic signed [SPEED_W-1:0]      m_right_next;

    // stage advance
    logic o_ready;
    logic c_ready;
    logic b_ready;
    logic a_ready;
    logic i_ready;
    logic a_load;

    // stage combinational
    logic                     lw, cw, rw, aw, ab;
    logic                     li, ri;
    logic                     upd;
    logic signed [ERR_W-1:0]  err;
    logic signed [INTEG_W:0]  integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [WIDE_W-1:0] left_wide;
    logic signed [WIDE_W-1:0] right_wide;

    // a stage takes a new transfer when empty or when its content moves on
    assign o_ready = !m_valid_reg || m_ready;
    assign c_ready = !c_valid_reg || o_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign i_ready = !i_valid_reg || a_ready;
    assign a_load  = i_valid_reg && a_ready;

    assign s_ready   = i_ready;
    assign cfg_ready = 1'b1;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_TAPE;
            base_speed_reg <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            white_thr_reg  <= '0;
            ir_thr_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE:            mode_reg       <= mode_t'(cfg_data[0]);
                CFG_BASE_SPEED:      base_speed_reg <= cfg_data[BASE_W-1:0];
                CFG_GAIN_P:          gain_p_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:          gain_i_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:          gain_d_reg     <= cfg_data[GAIN_W-1:0];
                CFG_WHITE_THRESHOLD: white_thr_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_IR_THRESHOLD:    ir_thr_reg     <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (i_ready) begin
                i_valid_reg <= s_valid;
            end
            if (a_ready) begin
                a_valid_reg <= i_valid_reg;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_ready) begin
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    // capture the step
    always_ff @(posedge aclk) begin
        if (s_valid && i_ready) begin
            i_kind_reg   <= kind_t'(s_kind);
            i_left_reg   <= s_left_sample;
            i_centre_reg <= s_centre_sample;
            i_right_reg  <= s_right_sample;
        end
    end

    // threshold the samples and look up the position error
    always_comb begin
        lw = i_left_reg < white_thr_reg;
        cw = i_centre_reg < white_thr_reg;
        rw = i_right_reg < white_thr_reg;
        aw = lw && cw && rw;
        ab = !lw && !cw && !rw;
        li = i_left_reg > ir_thr_reg;
        ri = i_right_reg > ir_thr_reg;

        err = '0;
        if (mode_reg == MODE_TAPE) begin
            if (aw) begin
                if (prev_err_reg > 0) begin
                    err = TAPE_THREE_OFF_LEVEL;
                end else if (prev_err_reg < 0) begin
                    err = -TAPE_THREE_OFF_LEVEL;
                end
            end else if (!lw && cw && rw) begin
                err = TAPE_TWO_OFF_LEVEL;
            end else if (lw && cw && !rw) begin
                err = -TAPE_TWO_OFF_LEVEL;
            end else if (!lw && !cw && rw) begin
                err = TAPE_ONE_OFF_LEVEL;
            end else if (lw && !cw && !rw) begin
                err = -TAPE_ONE_OFF_LEVEL;
            end
        end else begin
            if (li && !ri) begin
                err = IR_ONE_OFF_LEVEL;
            end else if (!li && ri) begin
                err = -IR_ONE_OFF_LEVEL;
            end
        end

        // a clear step or all black on tape holds the integral and gives no speeds
        upd = (i_kind_reg == KIND_SAMPLE) && !((mode_reg == MODE_TAPE) && ab);

        // saturating integral
        integ_sum = {integ_reg[INTEG_W-1], integ_reg}
                  + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (integ_sum > INTEG_MAX) begin
            integ_sat = INTEG_MAX[INTEG_W-1:0];
        end else if (integ_sum < INTEG_MIN) begin
            integ_sat = INTEG_MIN[INTEG_W-1:0];
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end

        a_err_next  = err;
        a_diff_next = {err[ERR_W-1], err} - {prev_err_reg[ERR_W-1], prev_err_reg};
        integ_next  = upd ? integ_sat : integ_reg;
        if (i_kind_reg == KIND_CLEAR) begin
            prev_err_next = '0;
        end else if (upd) begin
            prev_err_next = err;
        end else begin
            prev_err_next = prev_err_reg;
        end

        a_info_next = '0;
        if (i_kind_reg == KIND_SAMPLE) begin
            a_info_next.error_value  = upd ? err : ALL_HIGH_CODE;
            a_info_next.speeds_valid = upd;
            a_info_next.all_white    = aw;
            a_info_next.all_black    = ab;
            a_info_next.centre_white = cw;
        end
    end

    // controller state advances as each step leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end else if (a_load) begin
            prev_err_reg <= prev_err_next;
            integ_reg    <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_info_reg  <= a_info_next;
            a_err_reg   <= a_err_next;
            a_diff_reg  <= a_diff_next;
            a_integ_reg <= integ_next;
        end
    end

    // gain products
    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            b_info_reg  <= a_info_reg;
            b_prop_reg  <= a_err_reg * gain_p_reg;
            b_integ_reg <= a_integ_reg * gain_i_reg;
            b_diff_reg  <= a_diff_reg * gain_d_reg;
        end
    end

    // sum the terms and drop the Q8.8 fraction toward zero
    always_comb begin
        c_sum = {{(SUM_W-PROP_PROD_W){b_prop_reg[PROP_PROD_W-1]}}, b_prop_reg}
              + {{(SUM_W-INTEG_PROD_W){b_integ_reg[INTEG_PROD_W-1]}}, b_integ_reg}
              + {{(SUM_W-DIFF_PROD_W){b_diff_reg[DIFF_PROD_W-1]}}, b_diff_reg};
        c_corr_next = c_sum[SUM_W-1:FRAC_W]
                    + CORR_W'(c_sum[SUM_W-1] && (c_sum[FRAC_W-1:0] != '0));
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && c_ready) begin
            c_info_reg <= b_info_reg;
            c_corr_reg <= c_corr_next;
        end
    end

    // wheel speeds, saturated to the output width
    always_comb begin
        left_wide  = {{(WIDE_W-BASE_W){base_speed_reg[BASE_W-1]}}, base_speed_reg}
                   - {c_corr_reg[CORR_W-1], c_corr_reg};
        right_wide = {{(WIDE_W-BASE_W){base_speed_reg[BASE_W-1]}}, base_speed_reg}
                   + {c_corr_reg[CORR_W-1], c_corr_reg};

        if (left_wide > SPEED_MAX) begin
            m_left_next = SPEED_MAX[SPEED_W-1:0];
        end else if (left_wide < SPEED_MIN) begin
            m_left_next = SPEED_MIN[SPEED_W-1:0];
        end else begin
            m_left_next = left_wide[SPEED_W-1:0];
        end

        if (right_wide > SPEED_MAX) begin
            m_right_next = SPEED_MAX[SPEED_W-1:0];
        end else if (right_wide < SPEED_MIN) begin
            m_right_next = SPEED_MIN[SPEED_W-1:0];
        end else begin
            m_right_next = right_wide[SPEED_W-1:0];
        end

        if (!c_info_reg.speeds_valid) begin
            m_left_next  = '0;
            m_right_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg && o_ready) begin
            m_info_reg  <= c_info_reg;
            m_left_reg  <= m_left_next;
            m_right_reg <= m_right_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_error_value  = m_info_reg.error_value;
    assign m_left_speed   = m_left_reg;
    assign m_right_speed  = m_right_reg;
    assign m_speeds_valid = m_info_reg.speeds_valid;
    assign m_all_white    = m_info_reg.all_white;
    assign m_all_black    = m_info_reg.all_black;
    assign m_centre_white = m_info_reg.centre_white;

    // checks
    `LFPS_ASSERT_NOW(a_idle_speeds_zero, aclk, aresetn,
        m_valid && !m_speeds_valid, (m_left_speed == 0) && (m_right_speed == 0))
    `LFPS_ASSERT_NEXT(a_clear_drops_error, aclk, aresetn,
        a_load && (i_kind_reg == KIND_CLEAR), prev_err_reg == 0)
    `LFPS_ASSERT_NEXT(a_all_black_holds_state, aclk, aresetn,
        a_load && (i_kind_reg == KIND_SAMPLE) && (mode_reg == MODE_TAPE) && ab,
        $stable(prev_err_reg) && $stable(integ_reg))
    `LFPS_ASSERT_NOW(a_flags_exclusive, aclk, aresetn,
        m_valid && m_all_white, !m_all_black)

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the line follower PID steering block.
`timescale 1ns / 1ps
module testbench;
    import lfps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [SAMPLE_W-1:0] WHITE = 12'd0;
    localparam logic [SAMPLE_W-1:0] BLACK = 12'd4095;

    typedef struct {
        logic signed [ERR_W-1:0]   error_value;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      speeds_valid;
        logic                      all_white;
        logic                      all_black;
        logic                      centre_white;
    } steer_result_t;

    // Own copy of the steering controller plus the backlog of outstanding results
    class steering_tracker;
        mode_t                     mode;
        logic signed [BASE_W-1:0]  base;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic [SAMPLE_W-1:0]       white_thr;
        logic [SAMPLE_W-1:0]       ir_thr;
        logic signed [ERR_W-1:0]   last_err;
        logic signed [INTEG_W-1:0] integ;
        steer_result_t             steer_backlog[$];
        int                        faults;
        int                        steps;
        int                        clears;
        int                        black_steps;
        int                        checked;
        int                        settings;

        function new();
            mode      = MODE_TAPE;
            base      = '0;
            kp        = '0;
            ki        = '0;
            kd        = '0;
            white_thr = '0;
            ir_thr    = '0;
            last_err  = '0;
            integ     = '0;
        endfunction

        function longint bound(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (cfg_index_t'(idx))
                CFG_MODE:            mode      = mode_t'(data[0]);
                CFG_BASE_SPEED:      base      = data[BASE_W-1:0];
                CFG_GAIN_P:          kp        = data;
                CFG_GAIN_I:          ki        = data;
                CFG_GAIN_D:          kd        = data;
                CFG_WHITE_THRESHOLD: white_thr = data[SAMPLE_W-1:0];
                CFG_IR_THRESHOLD:    ir_thr    = data[SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the steering result of one accepted step and queue it
        function void note_step(kind_t kind, logic [SAMPLE_W-1:0] l,
                                logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] r);
            steer_result_t           res;
            logic                    lw, cw, rw, aw, ab, li, ri;
            logic signed [ERR_W-1:0] err;
            longint                  diff, acc, corr;
            res = '{default: '0};
            steps++;
            // clear drops the last error only; the integral stays
            if (kind == KIND_CLEAR) begin
                last_err = '0;
                clears++;
                steer_backlog.push_back(res);
                return;
            end
            lw = l < white_thr;
            cw = c < white_thr;
            rw = r < white_thr;
            aw = lw && cw && rw;
            ab = !lw && !cw && !rw;
            res.all_white    = aw;
            res.all_black    = ab;
            res.centre_white = cw;
            err = '0;
            if (mode == MODE_TAPE) begin
                // all black answers at once and leaves the state alone
                if (ab) begin
                    res.error_value = ALL_HIGH_CODE;
                    black_steps++;
                    steer_backlog.push_back(res);
                    return;
                end
                if (aw) begin
                    if (last_err > 0) err = TAPE_THREE_OFF_LEVEL;
                    else if (last_err < 0) err = -TAPE_THREE_OFF_LEVEL;
                end
                else if (!lw && cw && rw) err = TAPE_TWO_OFF_LEVEL;
                else if (lw && cw && !rw) err = -TAPE_TWO_OFF_LEVEL;
                else if (!lw && !cw && rw) err = TAPE_ONE_OFF_LEVEL;
                else if (lw && !cw && !rw) err = -TAPE_ONE_OFF_LEVEL;
            end else begin
                li = l > ir_thr;
                ri = r > ir_thr;
                if (li && !ri) err = IR_ONE_OFF_LEVEL;
                else if (!li && ri) err = -IR_ONE_OFF_LEVEL;
            end
            // saturating integral, then the exact Q8.8 sum truncated toward zero
            integ = INTEG_W'(bound(longint'(integ) + longint'(err),
                                   -64'sd8388608, 64'sd8388607));
            diff = longint'(err) - longint'(last_err);
            last_err = err;
            acc = longint'(err) * longint'(kp) + longint'(integ) * longint'(ki)
                + diff * longint'(kd);
            corr = acc / 256;
            res.error_value  = err;
            res.left_speed   = SPEED_W'(bound(longint'(base) - corr, -64'sd32768, 64'sd32767));
            res.right_speed  = SPEED_W'(bound(longint'(base) + corr, -64'sd32768, 64'sd32767));
            res.speeds_valid = 1'b1;
            steer_backlog.push_back(res);
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                faults++;
            end
        endfunction

        function void check_result(steer_result_t got);
            steer_result_t want;
            if (steer_backlog.size() == 0) begin
                $error("result with no step outstanding: error_value %0d", got.error_value);
                faults++;
                return;
            end
            want = steer_backlog.pop_front();
            checked++;
            compare_field("error_value", want.error_value, got.error_value);
            compare_field("left_speed", want.left_speed, got.left_speed);
            compare_field("right_speed", want.right_speed, got.right_speed);
            compare_field("speeds_valid", want.speeds_valid, got.speeds_valid);
            compare_field("all_white", want.all_white, got.all_white);
            compare_field("all_black", want.all_black, got.all_black);
            compare_field("centre_white", want.centre_white, got.centre_white);
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_kind = 1'b0;
    logic [SAMPLE_W-1:0]           s_left_sample = '0;
    logic [SAMPLE_W-1:0]           s_centre_sample = '0;
    logic [SAMPLE_W-1:0]           s_right_sample = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [ERR_W-1:0]       m_error_value;
    logic signed [SPEED_W-1:0]     m_left_speed;
    logic signed [SPEED_W-1:0]     m_right_speed;
    logic                          m_speeds_valid;
    logic                          m_all_white;
    logic                          m_all_black;
    logic                          m_centre_white;

    int                            cycle_count = 0;
    int                            stall_mode = 0;
    logic [15:0]                   stall_tick = '0;
    steering_tracker               sb = new();

    line_follow_pid_steering_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_left_sample   (s_left_sample),
        .s_centre_sample (s_centre_sample),
        .s_right_sample  (s_right_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_error_value   (m_error_value),
        .m_left_speed    (m_left_speed),
        .m_right_speed   (m_right_speed),
        .m_speeds_valid  (m_speeds_valid),
        .m_all_white     (m_all_white),
        .m_all_black     (m_all_black),
        .m_centre_white  (m_centre_white)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Bound the run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stall the result channel on a per-phase pattern
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom);
            2:       m_ready <= ($urandom_range(7, 0) != 0);
            default: m_ready <= (stall_tick[3:0] < 4'd5);
        endcase
    end

    // Observe every transfer on the three channels
    always @(posedge aclk) begin
        steer_result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                sb.note_step(kind_t'(s_kind), s_left_sample, s_centre_sample, s_right_sample);
            end
            if (m_valid && m_ready) begin
                got.error_value  = m_error_value;
                got.left_speed   = m_left_speed;
                got.right_speed  = m_right_speed;
                got.speeds_valid = m_speeds_valid;
                got.all_white    = m_all_white;
                got.all_black    = m_all_black;
                got.centre_white = m_centre_white;
                sb.check_result(got);
            end
        end
    end

    // Offer one register write and hold it until the transfer
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write every register; spare upper data bits carry noise
    task automatic configure(mode_t m, logic signed [BASE_W-1:0] base,
                             logic signed [GAIN_W-1:0] kp, logic signed [GAIN_W-1:0] ki,
                             logic signed [GAIN_W-1:0] kd, logic [SAMPLE_W-1:0] wthr,
                             logic [SAMPLE_W-1:0] irthr);
        logic [CFG_DATA_W-1:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_MODE, {junk[15:1], m});
        write_reg(CFG_BASE_SPEED, {junk[15:11], base});
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_WHITE_THRESHOLD, {junk[15:12], wthr});
        write_reg(CFG_IR_THRESHOLD, {junk[3:0], irthr});
        cfg_valid <= 1'b0;
        sb.settings++;
    endtask

    // Hold the sender until every outstanding result has come, then let the pipe settle;
    // wait for a clock edge first so the last accepted step is already in the backlog
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.steer_backlog.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Offer one step and hold it until the transfer
    task automatic send_step(kind_t kind, logic [SAMPLE_W-1:0] l,
                             logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] r);
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_left_sample   <= l;
        s_centre_sample <= c;
        s_right_sample  <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [SAMPLE_W-1:0] sample_near(logic [SAMPLE_W-1:0] thr, bit low);
        if (low) return (thr == 0) ? 12'd0 : 12'($urandom_range(thr - 1, 0));
        return 12'($urandom_range(4095, thr));
    endfunction

    function automatic logic signed [GAIN_W-1:0] mild_gain();
        return 16'($signed($urandom_range(1023, 0)) - 512);
    endfunction

    // Draw one step: mostly samples placed either side of the thresholds
    task automatic random_step();
        logic [SAMPLE_W-1:0] l, c, r;
        kind_t               kind;
        kind = ($urandom_range(11, 0) == 0) ? KIND_CLEAR : KIND_SAMPLE;
        if ($urandom_range(4, 0) == 0) begin
            l = 12'($urandom);
            c = 12'($urandom);
            r = 12'($urandom);
        end else begin
            c = sample_near(sb.white_thr, 1'($urandom));
            if (sb.mode == MODE_IR && $urandom_range(3, 0) != 0) begin
                l = sample_near(sb.ir_thr, 1'($urandom));
                r = sample_near(sb.ir_thr, 1'($urandom));
            end else begin
                l = sample_near(sb.white_thr, 1'($urandom));
                r = sample_near(sb.white_thr, 1'($urandom));
            end
        end
        send_step(kind, l, c, r);
    endtask

    // Send bursts of random length, with idle gaps between them when asked
    task automatic run_phase(int count, bit gappy, bit hold_midway);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(24, 1);
            for (int k = 0; k < burst && sent < count; k++) begin
                random_step();
                sent++;
                if (hold_midway && sent == count / 2) drain();
            end
            if (gappy) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed tape steps: every row of the position table and the lost-tape sign
        write_reg(CFG_SPARE, 16'($urandom));
        configure(MODE_TAPE, 11'sd100, 16'sh0100, 16'sh0010, 16'sh0200, 12'd2048, 12'd2048);
        send_step(KIND_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom));
        send_step(KIND_SAMPLE, WHITE, WHITE, WHITE);
        send_step(KIND_SAMPLE, BLACK, WHITE, WHITE);
        send_step(KIND_SAMPLE, WHITE, WHITE, WHITE);
        send_step(KIND_SAMPLE, BLACK, BLACK, WHITE);
        send_step(KIND_SAMPLE, WHITE, BLACK, BLACK);
        send_step(KIND_SAMPLE, WHITE, WHITE, BLACK);
        send_step(KIND_SAMPLE, WHITE, WHITE, WHITE);
        send_step(KIND_SAMPLE, BLACK, BLACK, BLACK);
        send_step(KIND_SAMPLE, BLACK, WHITE, BLACK);
        send_step(KIND_SAMPLE, WHITE, BLACK, WHITE);
        send_step(KIND_SAMPLE, 12'd2047, 12'd2047, 12'd2048);
        send_step(KIND_SAMPLE, 12'd2048, 12'd2047, 12'd2047);
        send_step(KIND_CLEAR, WHITE, WHITE, WHITE);
        send_step(KIND_SAMPLE, WHITE, WHITE, WHITE);
        drain();

        // Directed IR steps at the threshold edge, under extreme gains
        configure(MODE_IR, -11'sd1024, 16'sh7fff, 16'sh8000, 16'sh7fff, 12'd0, 12'd1000);
        send_step(KIND_SAMPLE, BLACK, WHITE, WHITE);
        send_step(KIND_SAMPLE, WHITE, BLACK, BLACK);
        send_step(KIND_SAMPLE, BLACK, BLACK, BLACK);
        send_step(KIND_SAMPLE, 12'd1000, WHITE, 12'd1001);
        send_step(KIND_SAMPLE, 12'd1001, WHITE, 12'd1000);
        send_step(KIND_SAMPLE, WHITE, WHITE, WHITE);
        send_step(KIND_CLEAR, BLACK, BLACK, BLACK);
        send_step(KIND_SAMPLE, BLACK, BLACK, BLACK);

        // Random phases, each under its own settings and one of four stall patterns
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            case (ph)
                0: configure(MODE_TAPE, 11'($urandom), mild_gain(), mild_gain(), mild_gain(),
                             12'($urandom), 12'($urandom));
                1: configure(MODE_IR, 11'($urandom), mild_gain(), mild_gain(), mild_gain(),
                             12'($urandom), 12'($urandom));
                2: configure(MODE_TAPE, 11'sd1023, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                             12'd4095, 12'd0);
                3: configure(MODE_TAPE, -11'sd1024, 16'sh8000, 16'sh8000, 16'sh8000,
                             12'($urandom), 12'd4095);
                4: configure(MODE_TAPE, 11'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 12'd0, 12'($urandom));
                5: configure(MODE_IR, 11'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 12'($urandom), 12'd0);
                6: configure(MODE_IR, 11'($urandom), mild_gain(), mild_gain(), mild_gain(),
                             12'($urandom), 12'd4095);
                default: configure(mode_t'(1'($urandom)), 11'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom), 12'($urandom),
                                   12'($urandom));
            endcase
            stall_mode <= ph % 4;
            run_phase((ph == 4) ? 40 : 205, (ph % 3) != 0, ph == 3);
        end

        // Wait out the last results and the pipeline
        @(posedge aclk);
        while (sb.steer_backlog.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Ran %0d steps (%0d clears, %0d all-black answers) over %0d register settings,",
                 sb.steps, sb.clears, sb.black_steps, sb.settings);
        $display("with bursty input and stalled output; %0d results compared field by field.",
                 sb.checked);
        if (sb.faults == 0 && sb.steer_backlog.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lfps_pkg.sv
hdl/line_follow_pid_steering_top.sv
bench/testbench.sv
